[sv/dmwc_pkg.sv]
// Shared types and constants for the direct-mapped write-back cache.
`default_nettype none

package dmwc_pkg;

    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_MOVE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_bk_ctl;

endpackage

`default_nettype wire

[sv/dmwc_backing.sv]
// Backing memory with its power-up load sweep and one read and one write port.
`default_nettype none

module dmwc_backing #(
    parameter int MEM_BYTES = 2048,
    localparam int MA_W = $clog2(MEM_BYTES)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    output logic                            o_ready,
    input  wire dmwc_pkg::t_bk_ctl          i_ctl,
    input  wire logic [MA_W-1:0]            i_rd_addr,
    output logic [dmwc_pkg::DATA_W-1:0]     o_rd_data,
    input  wire logic [MA_W-1:0]            i_wr_addr,
    input  wire logic [dmwc_pkg::DATA_W-1:0] i_wr_data
);
    import dmwc_pkg::*;

    logic [DATA_W-1:0] mem_bk [MEM_BYTES];

    logic            r_busy;
    logic [MA_W-1:0] r_init_addr;
    logic            n_busy;
    logic [MA_W-1:0] n_init_addr;

    logic              we;
    logic [MA_W-1:0]   waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] r_rd_data;

    // After reset every byte is loaded with the low byte of its own address.
    always_comb begin
        n_busy      = r_busy;
        n_init_addr = r_init_addr;
        if (r_busy) begin
            n_init_addr = r_init_addr + MA_W'(1);
            if (r_init_addr == MA_W'(MEM_BYTES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_init_addr <= '0;
        end else begin
            r_busy      <= n_busy;
            r_init_addr <= n_init_addr;
        end
    end

    always_comb begin
        if (r_busy) begin
            we    = 1'b1;
            waddr = r_init_addr;
            wdata = r_init_addr[DATA_W-1:0];
        end else begin
            we    = i_ctl.wr_en;
            waddr = i_wr_addr;
            wdata = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_bk[waddr] <= wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem_bk[i_rd_addr];
        end
    end

    assign o_ready   = !r_busy;
    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/direct_mapped_writeback_cache.sv]
// Direct-mapped write-back write-allocate byte cache with its own backing memory.
// A hit passes through the LOOK and RESP states and a miss through LOOK, MOVE and RESP, with
// the result registered in RESP. In MOVE one byte a cycle goes through the line and backing
// memory ports, the victim write-back overlapped with the refill. One request is in flight at
// a time; the next can be accepted in the cycle after the result registers.
// After reset the block stalls while the backing memory loads.
// Parameters must be powers of two.
`default_nettype none

module direct_mapped_writeback_cache #(
    parameter int NUM_LINES  = 16,
    parameter int LINE_BYTES = 16,
    parameter int MEM_BYTES  = 2048
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_opcode,
    input  wire logic [dmwc_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [dmwc_pkg::DATA_W-1:0]  i_write_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_hit,
    output logic                              o_wrote_back,
    output logic [dmwc_pkg::DATA_W-1:0]       o_data
);
    import dmwc_pkg::*;

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int LN_W  = $clog2(NUM_LINES);
    localparam int IX_W  = LN_W + OFF_W;
    localparam int MA_W  = $clog2(MEM_BYTES);
    localparam int AX_W  = (MA_W > ADDR_W) ? MA_W : ADDR_W;
    localparam int EA_W  = (MA_W > IX_W) ? MA_W : IX_W + 1;
    localparam int TAG_W = EA_W - IX_W;
    localparam int CNT_W = OFF_W + 1;

    // Address split of the incoming request, after wrapping into the memory.
    logic [AX_W-1:0]  in_ax;
    logic [EA_W-1:0]  in_ea;
    logic [OFF_W-1:0] in_ofs;
    logic [LN_W-1:0]  in_ln;
    logic [TAG_W-1:0] in_tag;

    assign in_ax  = AX_W'(i_address);
    assign in_ea  = EA_W'(in_ax[MA_W-1:0]);
    assign in_ofs = in_ea[OFF_W-1:0];
    assign in_ln  = in_ea[IX_W-1:OFF_W];
    assign in_tag = in_ea[EA_W-1:IX_W];

    t_state r_state;
    t_state n_state;

    logic                  r_op;
    logic [OFF_W-1:0]      r_ofs;
    logic [LN_W-1:0]       r_ln;
    logic [TAG_W-1:0]      r_tag;
    logic [DATA_W-1:0]     r_wd;
    logic [TAG_W-1:0]      r_vtag;
    logic                  r_spill;
    logic                  r_hit;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_W-1:0]     r_res_data;
    logic [NUM_LINES-1:0]  r_line_valid;

    logic                  r_o_valid;
    logic                  r_o_hit;
    logic                  r_o_wb;
    logic [DATA_W-1:0]     r_o_data;

    // Line store holds the cached bytes; tag store holds {tag, dirty} per line.
    logic [DATA_W-1:0] mem_line [NUM_LINES*LINE_BYTES];
    logic [TAG_W:0]    mem_meta [NUM_LINES];
    logic [DATA_W-1:0] r_line_rd;
    logic [TAG_W:0]    r_meta_rd;

    logic              bk_ready;
    t_bk_ctl           bk_ctl;
    logic [MA_W-1:0]   bk_raddr;
    logic [MA_W-1:0]   bk_waddr;
    logic [DATA_W-1:0] bk_rd_data;

    logic              accept;
    logic              out_free;
    logic              look_hit;
    logic              cnt_done;
    logic [OFF_W-1:0]  wofs;
    logic [DATA_W-1:0] fill_byte;

    logic              line_re;
    logic [IX_W-1:0]   line_raddr;
    logic              line_we;
    logic [IX_W-1:0]   line_waddr;
    logic [DATA_W-1:0] line_wdata;
    logic              meta_we;
    logic [TAG_W:0]    meta_wdata;
    logic              out_load;

    logic [EA_W-1:0]   fill_ea;
    logic [EA_W-1:0]   spill_ea;

    assign accept   = (r_state == ST_IDLE) && i_valid;
    assign out_free = !r_o_valid || !i_stall;
    assign look_hit = r_line_valid[r_ln] && (r_meta_rd[TAG_W:1] == r_tag);
    assign cnt_done = (r_cnt == CNT_W'(LINE_BYTES));
    assign wofs     = r_cnt[OFF_W-1:0] - OFF_W'(1);

    // On a write miss the new byte replaces the refill byte at its offset.
    assign fill_byte = ((r_op == OP_WRITE) && (wofs == r_ofs)) ? r_wd : bk_rd_data;

    assign fill_ea  = {r_tag, r_ln, r_cnt[OFF_W-1:0]};
    assign spill_ea = {r_vtag, r_ln, wofs};
    assign bk_raddr = fill_ea[MA_W-1:0];
    assign bk_waddr = spill_ea[MA_W-1:0];

    dmwc_backing #(
        .MEM_BYTES (MEM_BYTES)
    ) u_backing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_ready   (bk_ready),
        .i_ctl     (bk_ctl),
        .i_rd_addr (bk_raddr),
        .o_rd_data (bk_rd_data),
        .i_wr_addr (bk_waddr),
        .i_wr_data (r_line_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (bk_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = look_hit ? ST_RESP : ST_MOVE;
            end
            ST_MOVE: begin
                if (cnt_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        line_re    = 1'b0;
        line_raddr = {r_ln, r_cnt[OFF_W-1:0]};
        line_we    = 1'b0;
        line_waddr = {r_ln, wofs};
        line_wdata = fill_byte;
        meta_we    = 1'b0;
        meta_wdata = {r_tag, r_op};
        bk_ctl     = '0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                line_re    = i_valid;
                line_raddr = {in_ln, in_ofs};
            end
            ST_LOOK: begin
                if (look_hit && (r_op == OP_WRITE)) begin
                    line_we    = 1'b1;
                    line_waddr = {r_ln, r_ofs};
                    line_wdata = r_wd;
                    meta_we    = 1'b1;
                end
            end
            ST_MOVE: begin
                // Byte k is read from both stores, then written across in the next cycle.
                line_re      = !r_cnt[OFF_W];
                bk_ctl.rd_en = !r_cnt[OFF_W];
                line_we      = (r_cnt != '0);
                bk_ctl.wr_en = (r_cnt != '0) && r_spill;
                meta_we      = cnt_done;
            end
            ST_RESP: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            mem_line[line_waddr] <= line_wdata;
        end
        if (line_re) begin
            r_line_rd <= mem_line[line_raddr];
        end
        if (meta_we) begin
            mem_meta[r_ln] <= meta_wdata;
        end
        if (accept) begin
            r_meta_rd <= mem_meta[in_ln];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_line_valid <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (meta_we) begin
                r_line_valid[r_ln] <= 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_ofs <= in_ofs;
            r_ln  <= in_ln;
            r_tag <= in_tag;
            r_wd  <= i_write_data;
        end
        if (r_state == ST_LOOK) begin
            r_hit   <= look_hit;
            r_vtag  <= r_meta_rd[TAG_W:1];
            r_spill <= !look_hit && r_line_valid[r_ln] && r_meta_rd[0];
            r_cnt   <= '0;
            r_res_data <= (r_op == OP_READ) ? r_line_rd : r_wd;
        end
        if (r_state == ST_MOVE) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if ((r_cnt != '0) && (wofs == r_ofs)) begin
                r_res_data <= fill_byte;
            end
        end
        if (out_load) begin
            r_o_hit  <= r_hit;
            r_o_wb   <= r_spill;
            r_o_data <= r_res_data;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_hit        = r_o_hit;
    assign o_wrote_back = r_o_wb;
    assign o_data       = r_o_data;

endmodule

`default_nettype wire

[sv/dmwc_checker.sv]
// Port-level checks for the direct-mapped write-back cache and their binding.
`default_nettype none

module dmwc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_opcode,
    input wire logic [10:0] i_address,
    input wire logic [7:0] i_write_data,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_hit,
    input wire logic       o_wrote_back,
    input wire logic [7:0] o_data
);

    // A result that is held back keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data) && $stable(o_hit))
        else $error("stalled result changed");

    // Only one request is worked on at a time.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted while one is in flight");

    // A write-back only happens on a miss.
    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_wrote_back))
        else $error("write-back reported on a hit");

    // Reset empties the output and blocks requests during the memory load.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("block not quiet after reset");

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_dmwc_checker (.*);

`default_nettype wire

[bench/cache_access_checker.sv]
// Checker that predicts every cache access and compares each result with the prediction.
`default_nettype none

module cache_access_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         o_stall,
    input  wire logic                         i_opcode,
    input  wire logic [dmwc_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [dmwc_pkg::DATA_W-1:0]  i_write_data,
    input  wire logic                         o_valid,
    input  wire logic                         i_stall,
    input  wire logic                         o_hit,
    input  wire logic                         o_wrote_back,
    input  wire logic [dmwc_pkg::DATA_W-1:0]  o_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dmwc_pkg::*;

    localparam int NUM_LINES  = 16;
    localparam int LINE_BYTES = 16;
    localparam int MEM_BYTES  = 2048;

    typedef struct packed {
        logic              hit;
        logic              wrote_back;
        logic [DATA_W-1:0] data;
    } t_cache_reply;

    logic              line_valid [NUM_LINES];
    logic [2:0]        line_tag   [NUM_LINES];
    logic              line_dirty [NUM_LINES];
    logic [DATA_W-1:0] line_bytes [NUM_LINES*LINE_BYTES];
    logic [DATA_W-1:0] backing    [MEM_BYTES];

    t_cache_reply replies_due[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = replies_due.size();

    initial begin
        for (int i = 0; i < NUM_LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = 3'd0;
            line_dirty[i] = 1'b0;
        end
        for (int i = 0; i < NUM_LINES*LINE_BYTES; i++) begin
            line_bytes[i] = '0;
        end
        for (int i = 0; i < MEM_BYTES; i++) begin
            backing[i] = i[7:0];
        end
    end

    function automatic t_cache_reply predict_access(logic op, logic [ADDR_W-1:0] addr,
                                                    logic [DATA_W-1:0] wdata);
        t_cache_reply  r;
        logic [2:0]    tag;
        logic [3:0]    ln;
        logic [3:0]    off;
        logic [10:0]   base;
        tag = addr[10:8];
        ln  = addr[7:4];
        off = addr[3:0];
        r.hit        = line_valid[ln] && (line_tag[ln] == tag);
        r.wrote_back = 1'b0;
        if (!r.hit) begin
            // The dirty victim goes back to memory before the refill reads it.
            if (line_valid[ln] && line_dirty[ln]) begin
                base = {line_tag[ln], ln, 4'd0};
                for (int k = 0; k < LINE_BYTES; k++) begin
                    backing[base + k] = line_bytes[{ln, k[3:0]}];
                end
                r.wrote_back = 1'b1;
            end
            base = {tag, ln, 4'd0};
            for (int k = 0; k < LINE_BYTES; k++) begin
                line_bytes[{ln, k[3:0]}] = backing[base + k];
            end
            line_valid[ln] = 1'b1;
            line_tag[ln]   = tag;
            line_dirty[ln] = 1'b0;
        end
        if (op == OP_WRITE) begin
            line_bytes[{ln, off}] = wdata;
            line_dirty[ln]        = 1'b1;
        end
        r.data = line_bytes[{ln, off}];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cache_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with no request pending: hit=%0b wb=%0b data=%02h",
                             $time, o_hit, o_wrote_back, o_data);
            end else begin
                want = replies_due.pop_front();
                if (o_hit !== want.hit || o_wrote_back !== want.wrote_back ||
                    o_data !== want.data) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch: expected hit=%0b wb=%0b data=%02h, got %s",
                                 $time, want.hit, want.wrote_back, want.data,
                                 $sformatf("hit=%0b wb=%0b data=%02h",
                                           o_hit, o_wrote_back, o_data));
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall)
            replies_due.push_back(predict_access(i_opcode, i_address, i_write_data));
    end

endmodule

`default_nettype wire

[bench/direct_mapped_writeback_cache_test.sv]
// Top of the cache testbench: clock, reset, request and stall stimulus, and the verdict.
`default_nettype none

module direct_mapped_writeback_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmwc_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_opcode = OP_READ;
    logic [ADDR_W-1:0] i_address = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_hit;
    logic              o_wrote_back;
    logic [DATA_W-1:0] o_data;
    int                fail_count;
    int                pending;

    direct_mapped_writeback_cache uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_wrote_back (o_wrote_back),
        .o_data       (o_data)
    );

    cache_access_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_wrote_back (o_wrote_back),
        .o_data       (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_request(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_address    <= addr;
        i_write_data <= wdata;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_address    <= 11'($urandom_range(0, 2047));
            i_write_data <= 8'($urandom_range(0, 255));
        end
    endtask

    // The receiver alternates between free flow, light and heavy random stalls, and long holds.
    initial begin
        int pattern;
        int span;
        forever begin
            pattern = $urandom_range(0, 3);
            span    = (pattern == 3) ? $urandom_range(3, 20) : $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (pattern)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int               burst_left;
        logic             op;
        logic [ADDR_W-1:0] addr;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Cold misses at both ends of memory, then conflicts that force dirty write-backs.
        send_request(OP_READ,  11'h000, 8'h3C);
        send_request(OP_READ,  11'h7FF, 8'hC3);
        send_request(OP_WRITE, 11'h005, 8'hFF);
        send_request(OP_READ,  11'h005, 8'h00);
        send_request(OP_WRITE, 11'h105, 8'hAA);
        send_request(OP_READ,  11'h005, 8'h55);
        send_request(OP_READ,  11'h105, 8'hFF);
        send_request(OP_WRITE, 11'h7FF, 8'h00);
        send_request(OP_WRITE, 11'h7F0, 8'h55);
        send_request(OP_READ,  11'h0FF, 8'h00);
        send_request(OP_READ,  11'h7FF, 8'hFF);
        send_request(OP_WRITE, 11'h3A7, 8'h5A);
        send_request(OP_WRITE, 11'h3A7, 8'hA5);
        send_request(OP_WRITE, 11'h4A7, 8'h01);
        send_request(OP_READ,  11'h3A7, 8'h80);
        send_request(OP_WRITE, 11'h000, 8'h80);
        send_request(OP_READ,  11'h4A7, 8'h7F);
        send_request(OP_READ,  11'h000, 8'hFE);
        hold_off(3);

        // Most addresses stay in a few lines and tags so hits, conflicts and dirty
        // evictions keep happening; the rest roam the whole memory.
        burst_left = 0;
        for (int n = 0; n < 900; n++) begin
            if (burst_left == 0) begin
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            if ($urandom_range(0, 9) < 6)
                addr = {3'($urandom_range(0, 2)), 4'($urandom_range(0, 3)),
                        4'($urandom_range(0, 15))};
            else
                addr = 11'($urandom_range(0, 2047));
            send_request(op, addr, 8'($urandom_range(0, 255)));
        end
        hold_off(1);

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
